// ===== hdl/minmax_affine_int8_quantizer_core_defines.svh =====
// Assertion macros for the quantizer core; they expect clk and arst_n in scope.
`ifndef MINMAX_AFFINE_INT8_QUANTIZER_CORE_DEFINES_SVH
`define MINMAX_AFFINE_INT8_QUANTIZER_CORE_DEFINES_SVH

`define QMM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qmm: same-cycle check failed");

`define QMM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qmm: next-cycle check failed");

`endif

// ===== hdl/qmm_pkg.sv =====
`default_nettype none
package qmm_pkg;

	localparam int SMP_W     = 16;
	localparam int NUM_W     = 23;
	localparam int DEN_W     = 16;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int ZP_W      = 24;
	localparam int SUM_W     = 26;

	localparam logic signed [ZP_W-1:0]  ZP_OFFSET = 24'sd128;
	localparam logic signed [SUM_W-1:0] QV_MAX    = 26'sd127;
	localparam logic signed [SUM_W-1:0] QV_MIN    = -26'sd128;

	localparam logic ACT_OBSERVE  = 1'b0;
	localparam logic ACT_QUANTIZE = 1'b1;

	typedef struct packed {
		logic                    action;
		logic signed [SMP_W-1:0] sample_value;
		logic                    first_of_set;
	} sample_t;

	typedef struct packed {
		logic signed [7:0]      quantized_value;
		logic signed [ZP_W-1:0] zero_point_out;
		logic [DEN_W-1:0]       range_out;
		logic                   degenerate;
	} result_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] min;
		logic signed [SMP_W-1:0] max;
		logic                    valid;
	} stats_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} qmm_state_t;

endpackage
`default_nettype wire

// ===== hdl/qmm_stats.sv =====
`default_nettype none
module qmm_stats (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            update,
	input  wire logic                            first,
	input  wire logic signed [qmm_pkg::SMP_W-1:0] x,
	output qmm_pkg::stats_t                      stats
);
	import qmm_pkg::*;

	stats_t stats_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= '0;
		end else if (update) begin
			if (first || !stats_q.valid) begin
				stats_q.min   <= x;
				stats_q.max   <= x;
				stats_q.valid <= 1'b1;
			end else begin
				if (x < stats_q.min) stats_q.min <= x;
				if (x > stats_q.max) stats_q.max <= x;
			end
		end
	end

	assign stats = stats_q;

endmodule
`default_nettype wire

// ===== hdl/qmm_div.sv =====
`default_nettype none
module qmm_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qmm_pkg::div_req_t req,
	output qmm_pkg::div_res_t      res
);
	import qmm_pkg::*;

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		ge    = ~diff[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.quo  = num_q;
	assign res.rem  = rem_q;

endmodule
`default_nettype wire

// ===== hdl/minmax_affine_int8_quantizer_core.sv =====
// Each accepted request goes through LOAD, DIV and DONE before its result is registered;
// degenerate requests skip DIV. A new request is taken only once the previous result has
// left DONE; the 23-step bit-serial divider runs once per non-degenerate request.
// A finished result waits in the output register while the next request is taken.
// Reset: arst_n low clears statistics (no statistics, degenerate), result_valid and the divider; the core idles.
`default_nettype none
`include "minmax_affine_int8_quantizer_core_defines.svh"
module minmax_affine_int8_quantizer_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sample_valid,
	output logic                  sample_ready,
	input  wire qmm_pkg::sample_t sample,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output qmm_pkg::result_t      result
);
	import qmm_pkg::*;

	qmm_state_t state_q, state_d;

	stats_t   stats;
	div_req_t div_req;
	div_res_t div_res;

	logic                    accept;
	logic                    out_load;
	logic                    act_q;
	logic signed [SMP_W-1:0] x_q;
	logic                    sign_q;
	logic                    degen_q;
	logic [DEN_W-1:0]        range_q;
	logic signed [ZP_W-1:0]  zp_q;
	result_t                 result_q;
	logic                    result_valid_q;

	logic [SMP_W:0]          range_w;
	logic [DEN_W-1:0]        range_d;
	logic                    degen_d;
	logic signed [SMP_W:0]   op;
	logic signed [SMP_W+8:0] prod;
	logic [SMP_W+8:0]        mag;

	logic                    rnd;
	logic [NUM_W:0]          q_mag;
	logic signed [NUM_W+1:0] q_s;
	logic signed [ZP_W-1:0]  zp_new;
	logic signed [SUM_W-1:0] sum;
	result_t                 res_d;

	assign accept = sample_valid && sample_ready;

	qmm_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.update (accept && (sample.action == ACT_OBSERVE)),
		.first  (sample.first_of_set),
		.x      (sample.sample_value),
		.stats  (stats)
	);

	// range, numerator magnitude and sign from updated statistics
	always_comb begin
		range_w = {stats.max[SMP_W-1], stats.max} - {stats.min[SMP_W-1], stats.min};
		range_d = stats.valid ? range_w[DEN_W-1:0] : '0;
		degen_d = !stats.valid || (range_d == '0);
		op      = (act_q == ACT_OBSERVE) ? -{stats.min[SMP_W-1], stats.min}
		                                 : {x_q[SMP_W-1], x_q};
		prod    = {op, 8'b0} - {{8{op[SMP_W]}}, op};
		mag     = prod[SMP_W+8] ? 25'(-prod) : 25'(prod);
	end

	assign div_req.start = (state_q == ST_LOAD) && !degen_d;
	assign div_req.num   = mag[NUM_W-1:0];
	assign div_req.den   = range_d;

	qmm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_LOAD;
			ST_LOAD: state_d = degen_d ? ST_DONE : ST_DIV;
			ST_DIV:  if (div_res.done) state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready  = (state_q == ST_IDLE);
		out_load      = (state_q == ST_DONE) && (!result_valid_q || result_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= sample.action;
			x_q   <= sample.sample_value;
		end
		if (state_q == ST_LOAD) begin
			sign_q  <= prod[SMP_W+8];
			degen_q <= degen_d;
			range_q <= range_d;
		end
		if (out_load && !degen_q && (act_q == ACT_OBSERVE)) begin
			zp_q <= zp_new;
		end
	end

	// round, apply zero point and offset, saturate
	always_comb begin
		rnd    = (act_q == ACT_QUANTIZE) && ({div_res.rem, 1'b0} >= {1'b0, range_q});
		q_mag  = {1'b0, div_res.quo} + {{NUM_W{1'b0}}, rnd};
		q_s    = sign_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		zp_new = q_s[ZP_W-1:0];
		sum    = SUM_W'(q_s) + SUM_W'(zp_q) - SUM_W'(ZP_OFFSET);

		res_d            = '0;
		res_d.range_out  = range_q;
		res_d.degenerate = degen_q;
		if (!degen_q) begin
			if (act_q == ACT_OBSERVE) begin
				res_d.zero_point_out = zp_new - ZP_OFFSET;
			end else begin
				res_d.zero_point_out = zp_q - ZP_OFFSET;
				priority if (sum > QV_MAX) res_d.quantized_value = QV_MAX[7:0];
				else if (sum < QV_MIN) res_d.quantized_value = QV_MIN[7:0];
				else res_d.quantized_value = sum[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) result_q <= res_d;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`QMM_ASSERT_IMP(a_done_in_div, div_res.done, state_q == ST_DIV)
	`QMM_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, range_q != '0)
	`QMM_ASSERT_IMP(a_degen_zero, result_valid_q && result_q.degenerate,
		(result_q.quantized_value == '0) && (result_q.zero_point_out == '0))
	`QMM_ASSERT_NXT(a_start_busy, div_req.start, div_res.busy && (state_q == ST_DIV))

endmodule
`default_nettype wire

// ===== verif/minmax_affine_int8_quantizer_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module minmax_affine_int8_quantizer_core_tb;
	import qmm_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 750;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int ROWS         = 24;

	localparam result_t DEGEN = '{8'sd0, 24'sd0, 16'd0, 1'b1};
	localparam result_t UNIT_RANGE = '{8'sd0, -24'sd128, 16'd1, 1'b0};

	typedef struct packed {
		logic        action;
		logic [15:0] value;
		logic        first_of_set;
		logic        typed;
		result_t     want;
	} row_t;

	localparam row_t PLAN [ROWS] = '{
		'{ACT_QUANTIZE, 16'd0,    1'b0, 1'b1, DEGEN},
		'{ACT_OBSERVE,  16'd100,  1'b0, 1'b1, DEGEN},
		'{ACT_QUANTIZE, 16'd100,  1'b1, 1'b1, DEGEN},
		'{ACT_OBSERVE,  16'h8000, 1'b1, 1'b1, DEGEN},
		'{ACT_OBSERVE,  16'h7fff, 1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'h7fff, 1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'h8000, 1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'd0,    1'b1, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'hffff, 1'b0, 1'b0, DEGEN},
		'{ACT_OBSERVE,  16'd0,    1'b1, 1'b1, DEGEN},
		'{ACT_OBSERVE,  16'd1,    1'b0, 1'b1, UNIT_RANGE},
		'{ACT_QUANTIZE, 16'd1,    1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'h7fff, 1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'h8000, 1'b0, 1'b0, DEGEN},
		'{ACT_OBSERVE,  16'hffff, 1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'd0,    1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'hffff, 1'b0, 1'b0, DEGEN},
		'{ACT_OBSERVE,  16'd1000, 1'b1, 1'b1, DEGEN},
		'{ACT_OBSERVE,  16'd2000, 1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'd1500, 1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'h8000, 1'b1, 1'b0, DEGEN},
		'{ACT_OBSERVE,  16'd1500, 1'b0, 1'b0, DEGEN},
		'{ACT_OBSERVE,  16'h8000, 1'b0, 1'b0, DEGEN},
		'{ACT_QUANTIZE, 16'h7fff, 1'b0, 1'b0, DEGEN}
	};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_ready;
	sample_t sample;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int      stats_lo;
	int      stats_hi;
	bit      stats_seen;
	result_t pending_results [$];
	int      mismatches;
	int      cycle_cnt;
	bit      steady;
	bit      hold_req;
	int      sent_random;

	minmax_affine_int8_quantizer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic result_t quant_predict(input sample_t req);
		int      x;
		int      span;
		int      zp;
		int      qv;
		int      num;
		int      mag;
		int      quo;
		int      rem;
		bit      degen;
		result_t res;
		x = int'(req.sample_value);
		if (req.action == ACT_OBSERVE) begin
			if (req.first_of_set || !stats_seen) begin
				stats_lo = x;
				stats_hi = x;
				stats_seen = 1'b1;
			end else begin
				if (x < stats_lo) stats_lo = x;
				if (x > stats_hi) stats_hi = x;
			end
		end
		span = stats_seen ? stats_hi - stats_lo : 0;
		degen = !stats_seen || span == 0;
		zp = 0;
		qv = 0;
		if (!degen) begin
			zp = (-stats_lo * 255) / span;
			if (req.action == ACT_QUANTIZE) begin
				num = x * 255;
				mag = num < 0 ? -num : num;
				quo = mag / span;
				rem = mag % span;
				if (2 * rem >= span) quo++;
				qv = (num < 0 ? -quo : quo) + zp - 128;
				if (qv > 127) qv = 127;
				if (qv < -128) qv = -128;
			end
			zp -= 128;
		end
		res.quantized_value = qv[7:0];
		res.zero_point_out = zp[23:0];
		res.range_out = span[15:0];
		res.degenerate = degen;
		return res;
	endfunction

	function automatic logic [15:0] pick_value(input int center, input int spread);
		int v;
		v = center + int'($urandom_range(2 * spread)) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	task automatic send_request(input sample_t req, input bit typed, input result_t want);
		result_t predicted;
		while (!steady && $urandom_range(99) < 33) begin
			@(negedge clk);
			sample_valid <= 1'b0;
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= req;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		predicted = quant_predict(req);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic send_random(input logic act, input logic [15:0] value, input logic restart);
		sample_t req;
		req.action = act;
		req.sample_value = value;
		req.first_of_set = restart;
		if (sent_random == 100) hold_req = 1'b1;
		if (sent_random == 500) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			while (pending_results.size() != 0) @(posedge clk);
		end
		steady = sent_random >= 250 && sent_random < 400;
		send_request(req, 1'b0, DEGEN);
		sent_random++;
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: qv=%0d zp=%0d range=%0d degen=%0d",
						result.quantized_value, result.zero_point_out,
						result.range_out, result.degenerate);
			end else begin
				want = pending_results.pop_front();
				if (result.quantized_value !== want.quantized_value ||
					result.zero_point_out !== want.zero_point_out ||
					result.range_out !== want.range_out ||
					result.degenerate !== want.degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
							want.quantized_value, want.zero_point_out,
							want.range_out, want.degenerate,
							result.quantized_value, result.zero_point_out,
							result.range_out, result.degenerate);
				end
			end
		end
	end

	initial begin
		int hold_cnt;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
			end else begin
				result_ready <= steady || $urandom_range(99) >= 33;
			end
		end
	end

	initial begin
		sample_t req;
		int      row;
		int      n_obs;
		int      n_quant;
		int      center;
		int      spread;
		int      mode;
		int      k;
		logic [15:0] value;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		stats_lo = 0;
		stats_hi = 0;
		stats_seen = 1'b0;
		mismatches = 0;
		cycle_cnt = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		sent_random = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (row = 0; row < ROWS; row++) begin
			req.action = PLAN[row].action;
			req.sample_value = PLAN[row].value;
			req.first_of_set = PLAN[row].first_of_set;
			send_request(req, PLAN[row].typed, PLAN[row].want);
		end

		while (sent_random < RANDOM_ITEMS) begin
			center = int'($urandom_range(65535)) - 32768;
			mode = $urandom_range(99);
			if (mode < 10) spread = 0;
			else if (mode < 30) spread = $urandom_range(8, 1);
			else if (mode < 70) spread = $urandom_range(300, 1);
			else spread = $urandom_range(65535, 1);
			// stray requests ahead of a set
			if ($urandom_range(99) < 8)
				send_random(1'($urandom_range(1)), 16'($urandom_range(65535)),
					1'($urandom_range(1)));
			n_obs = $urandom_range(6, 1);
			for (k = 0; k < n_obs; k++)
				send_random(ACT_OBSERVE, pick_value(center, spread),
					k == 0 ? ($urandom_range(99) < 90) : ($urandom_range(99) < 5));
			n_quant = $urandom_range(8, 1);
			for (k = 0; k < n_quant; k++) begin
				if ($urandom_range(99) < 80) value = pick_value(center, spread + spread / 4 + 1);
				else value = 16'($urandom_range(65535));
				send_random(ACT_QUANTIZE, value, 1'($urandom_range(1)));
			end
		end
		steady = 1'b0;
		@(negedge clk);
		sample_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/qmm_pkg.sv
hdl/qmm_stats.sv
hdl/qmm_div.sv
hdl/minmax_affine_int8_quantizer_core.sv
verif/minmax_affine_int8_quantizer_core_tb.sv
